// ----- design/bcs_pkg.sv -----
// Shared types, constants and widths for the braking-curve speed supervisor.
package bcs_pkg;

    // Field widths.
    localparam int ASPECT_W = 3;
    localparam int DIST_W   = 16;
    localparam int SPEED_W  = 9;
    localparam int DECEL_W  = 9;

    // Aspect codes.
    localparam logic [ASPECT_W-1:0] ASPECT_STOP            = 3'd0;
    localparam logic [ASPECT_W-1:0] ASPECT_PROCEED         = 3'd1;
    localparam logic [ASPECT_W-1:0] ASPECT_PROCEED_LIMITED = 3'd2;
    localparam logic [ASPECT_W-1:0] ASPECT_STOP_BOARD      = 3'd3;

    // Distance margin and the short-distance threshold, in metres.
    localparam logic [DIST_W-1:0] DIST_MARGIN = 16'd15;
    localparam logic [DIST_W-1:0] MIN_DIST    = 16'd10;

    // Deceleration handling, in 0.01 m/s^2.
    localparam logic [DECEL_W-1:0] DECEL_RESET  = 9'd50;
    localparam logic [DECEL_W-1:0] DECEL_KNEE   = 9'd50;
    localparam logic [DECEL_W-1:0] DECEL_DERATE = 9'd10;

    // Scale factors of the squared speed, in (0.01 km/h)^2.
    localparam int SQ_SCALE_W    = 14;
    localparam int CURVE_SCALE_W = 12;
    localparam logic [SQ_SCALE_W-1:0]    SPEED_SQ_SCALE = 14'd10000;
    localparam logic [CURVE_SCALE_W-1:0] CURVE_SCALE    = 12'd2592;

    // Widths along the datapath.
    localparam int VV_W  = 2 * SPEED_W;
    localparam int AD_W  = DECEL_W + DIST_W;
    localparam int P1_W  = VV_W + SQ_SCALE_W;
    localparam int P2_W  = AD_W + CURVE_SCALE_W;
    localparam int X_W   = 38;
    localparam int ROOT_W = X_W / 2;
    localparam int REM_W  = ROOT_W + 2;

    // Output scaling of the root (units of 0.01 km/h).
    localparam logic [SPEED_W-1:0] MAX_SPEED = 9'd250;
    localparam int SROOT_W = 16;
    localparam logic [ROOT_W-1:0] MIN_ROOT   = 19'd1332;
    localparam logic [ROOT_W-1:0] CLAMP_ROOT = ROOT_W'((int'(MAX_SPEED) + 1) * 100);
    localparam int RECIP_W     = 18;
    localparam int RECIP_SHIFT = 24;
    localparam logic [RECIP_W-1:0] RECIP_100 = 18'd167773;

    // One beat moving through the square-root cells.
    typedef struct packed {
        logic               valid;
        logic [X_W-1:0]     x;
        logic [REM_W-1:0]   rem;
        logic [ROOT_W-1:0]  root;
        logic [SPEED_W-1:0] target;
    } sqrt_stage_t;

endpackage

// ----- design/bcs_front.sv -----
// Stop rules, margins and the squared-speed sum ahead of the square-root chain.
module bcs_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_beat,
    input  logic [bcs_pkg::ASPECT_W-1:0]  aspect,
    input  logic [bcs_pkg::DIST_W-1:0]    distance_m,
    input  logic [bcs_pkg::SPEED_W-1:0]   allowed_speed,
    input  logic                          platform_stop,
    input  logic                          shunting,
    input  logic [bcs_pkg::SPEED_W-1:0]   combined_limit,
    input  logic [bcs_pkg::DECEL_W-1:0]   decel,
    output bcs_pkg::sqrt_stage_t          stage_out
);
    import bcs_pkg::*;

    // Stage A: rules.
    logic               a_valid_reg, a_valid_next;
    logic [SPEED_W-1:0] a_v_reg, a_v_next;
    logic [DIST_W-1:0]  a_d_reg, a_d_next;
    logic               a_dok_reg, a_dok_next;
    logic [DECEL_W-1:0] a_a_reg, a_a_next;
    // Stage B: products.
    logic               b_valid_reg;
    logic [VV_W-1:0]    b_vv_reg, b_vv_next;
    logic [AD_W-1:0]    b_ad_reg, b_ad_next;
    logic               b_dok_reg;
    logic [SPEED_W-1:0] b_t_reg;
    // Stage C: scaled products.
    logic               c_valid_reg;
    logic [P1_W-1:0]    c_p1_reg, c_p1_next;
    logic [P2_W-1:0]    c_p2_reg, c_p2_next;
    logic [SPEED_W-1:0] c_t_reg;
    // Stage D: sum.
    logic               d_valid_reg;
    logic [X_W-1:0]     d_x_reg, d_x_next;
    logic [SPEED_W-1:0] d_t_reg;

    logic [SPEED_W-1:0] v_rule;

    always_comb
    begin
        v_rule = allowed_speed;
        if (platform_stop || aspect == ASPECT_STOP_BOARD)
        begin
            v_rule = '0;
        end
        else if (shunting)
        begin
            if (aspect == ASPECT_STOP)
            begin
                v_rule = '0;
            end
        end
        else if (!(aspect inside {ASPECT_PROCEED, ASPECT_PROCEED_LIMITED}))
        begin
            v_rule = '0;
        end
        a_v_next     = (combined_limit < v_rule) ? combined_limit : v_rule;
        a_d_next     = (distance_m > DIST_MARGIN) ? distance_m - DIST_MARGIN : '0;
        a_dok_next   = (a_d_next >= MIN_DIST);
        a_a_next     = (decel > DECEL_KNEE) ? decel - DECEL_DERATE : decel;
        a_valid_next = in_beat;
    end

    always_comb
    begin
        b_vv_next = VV_W'(a_v_reg) * VV_W'(a_v_reg);
        b_ad_next = AD_W'(a_a_reg) * AD_W'(a_d_reg);
        c_p1_next = P1_W'(b_vv_reg) * P1_W'(SPEED_SQ_SCALE);
        c_p2_next = b_dok_reg ? P2_W'(b_ad_reg) * P2_W'(CURVE_SCALE) : '0;
        d_x_next  = X_W'(c_p1_reg) + X_W'(c_p2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_v_reg   <= a_v_next;
            a_d_reg   <= a_d_next;
            a_dok_reg <= a_dok_next;
            a_a_reg   <= a_a_next;
            b_vv_reg  <= b_vv_next;
            b_ad_reg  <= b_ad_next;
            b_dok_reg <= a_dok_reg;
            b_t_reg   <= a_v_reg;
            c_p1_reg  <= c_p1_next;
            c_p2_reg  <= c_p2_next;
            c_t_reg   <= b_t_reg;
            d_x_reg   <= d_x_next;
            d_t_reg   <= c_t_reg;
        end
    end

    always_comb
    begin
        stage_out.valid  = d_valid_reg;
        stage_out.x      = d_x_reg;
        stage_out.rem    = '0;
        stage_out.root   = '0;
        stage_out.target = d_t_reg;
    end

endmodule

// ----- design/bcs_sqrt_cell.sv -----
// One digit cell of the square-root chain: settles one bit of the root per beat.
module bcs_sqrt_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  bcs_pkg::sqrt_stage_t prev,
    output bcs_pkg::sqrt_stage_t next
);
    import bcs_pkg::*;

    logic               valid_reg;
    logic [X_W-1:0]     x_reg, x_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [SPEED_W-1:0] target_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;

    // Bring down the next two bits of the radicand and try a one digit.
    always_comb
    begin
        rem_shift = {prev.rem[REM_W-3:0], prev.x[X_W-1 -: 2]};
        trial     = {prev.root, 2'b01};
        x_next    = {prev.x[X_W-3:0], 2'b00};
        if (rem_shift >= trial)
        begin
            rem_next  = rem_shift - trial;
            root_next = {prev.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_shift;
            root_next = {prev.root[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= prev.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg      <= x_next;
            rem_reg    <= rem_next;
            root_reg   <= root_next;
            target_reg <= prev.target;
        end
    end

    always_comb
    begin
        next.valid  = valid_reg;
        next.x      = x_reg;
        next.rem    = rem_reg;
        next.root   = root_reg;
        next.target = target_reg;
    end

endmodule

// ----- design/braking_curve_speed_supervisor.sv -----
// Braking-curve speed supervisor: front stages, square-root cell chain, output scaling.
// An accepted input beat reaches its result through four front stages,
// one square-root cell per root bit (19), and the output register.
// Throughput is one beat per cycle; the whole pipeline holds only while a result
// waits at the output under stall.
// Reset clears all valid flags and sets the deceleration register to 50.
module braking_curve_speed_supervisor (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcs_pkg::DECEL_W-1:0]   deceleration_centi,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bcs_pkg::ASPECT_W-1:0]  aspect,
    input  logic [bcs_pkg::DIST_W-1:0]    distance_m,
    input  logic [bcs_pkg::SPEED_W-1:0]   allowed_speed,
    input  logic                          platform_stop,
    input  logic                          shunting,
    input  logic [bcs_pkg::SPEED_W-1:0]   combined_limit,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bcs_pkg::SPEED_W-1:0]   supervised_speed,
    output logic [bcs_pkg::SPEED_W-1:0]   target_speed
);
    import bcs_pkg::*;

    logic [DECEL_W-1:0] decel_reg;
    logic               en;
    logic               in_beat;

    sqrt_stage_t chain [ROOT_W+1];

    logic               out_valid_reg;
    logic [SPEED_W-1:0] sup_reg, sup_next;
    logic [SPEED_W-1:0] tgt_reg;

    logic [ROOT_W-1:0]          root;
    logic [SROOT_W+RECIP_W-1:0] quot_prod;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decel_reg <= DECEL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            decel_reg <= deceleration_centi;
        end
    end

    // Everything advances unless a finished result is held by the consumer.
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;
    assign in_beat  = in_valid && en;

    bcs_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .en             (en),
        .in_beat        (in_beat),
        .aspect         (aspect),
        .distance_m     (distance_m),
        .allowed_speed  (allowed_speed),
        .platform_stop  (platform_stop),
        .shunting       (shunting),
        .combined_limit (combined_limit),
        .decel          (decel_reg),
        .stage_out      (chain[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        bcs_sqrt_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .en    (en),
            .prev  (chain[i]),
            .next  (chain[i+1])
        );
    end

    // Root is in 0.01 km/h; divide by 100 through a reciprocal, exact below the clamp.
    always_comb
    begin
        root      = chain[ROOT_W].root;
        quot_prod = (SROOT_W+RECIP_W)'(root[SROOT_W-1:0]) * (SROOT_W+RECIP_W)'(RECIP_100);
        if (root >= CLAMP_ROOT)
        begin
            sup_next = MAX_SPEED;
        end
        else if (root < MIN_ROOT)
        begin
            sup_next = '0;
        end
        else
        begin
            sup_next = quot_prod[RECIP_SHIFT +: SPEED_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= chain[ROOT_W].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sup_reg <= sup_next;
            tgt_reg <= chain[ROOT_W].target;
        end
    end

    assign out_valid        = out_valid_reg;
    assign supervised_speed = sup_reg;
    assign target_speed     = tgt_reg;

endmodule

// ----- tb/tb_braking_curve_speed_supervisor.sv -----
// Self-checking testbench for the braking-curve speed supervisor pipeline.
`timescale 1ns / 100ps

module tb_braking_curve_speed_supervisor;

    import bcs_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 11;
    localparam int DRAIN_CYCLES = 30;
    localparam int STALL_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [SPEED_W-1:0] supervised;
        logic [SPEED_W-1:0] target;
    } speed_result_t;

    logic                clk                = 1'b0;
    logic                rst_n              = 1'b0;
    logic                cfg_valid          = 1'b0;
    logic                cfg_ready;
    logic [DECEL_W-1:0]  deceleration_centi = '0;
    logic                in_valid           = 1'b0;
    logic                in_stall;
    logic [ASPECT_W-1:0] aspect             = '0;
    logic [DIST_W-1:0]   distance_m         = '0;
    logic [SPEED_W-1:0]  allowed_speed      = '0;
    logic                platform_stop      = 1'b0;
    logic                shunting           = 1'b0;
    logic [SPEED_W-1:0]  combined_limit     = '0;
    logic                out_valid;
    logic                out_stall          = 1'b0;
    logic [SPEED_W-1:0]  supervised_speed;
    logic [SPEED_W-1:0]  target_speed;

    // Testbench copy of the deceleration register.
    logic [DECEL_W-1:0] decel_setting = DECEL_RESET;

    speed_result_t expected_speeds[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    int error_count   = 0;
    int signals_sent  = 0;
    int results_seen  = 0;
    int decel_writes  = 0;
    int quiet_cycles  = 0;

    braking_curve_speed_supervisor u_dut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .deceleration_centi (deceleration_centi),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .aspect             (aspect),
        .distance_m         (distance_m),
        .allowed_speed      (allowed_speed),
        .platform_stop      (platform_stop),
        .shunting           (shunting),
        .combined_limit     (combined_limit),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .supervised_speed   (supervised_speed),
        .target_speed       (target_speed)
    );

    always #CLK_HALF clk = ~clk;

    function automatic logic [31:0] exact_root(input logic [63:0] x);
        logic [31:0] root;
        logic [63:0] trial;
        int          b;
        root = '0;
        for (b = 31; b >= 0; b--)
        begin
            trial = 64'(root) | (64'd1 << b);
            if (trial * trial <= x)
                root = trial[31:0];
        end
        return root;
    endfunction

    function automatic speed_result_t predict_speeds(
        input logic [ASPECT_W-1:0] asp,
        input logic [DIST_W-1:0]   dist_val,
        input logic [SPEED_W-1:0]  allowed,
        input logic                pstop,
        input logic                shunt,
        input logic [SPEED_W-1:0]  limit,
        input logic [DECEL_W-1:0]  decel
    );
        speed_result_t res;
        logic [SPEED_W-1:0] v;
        logic [DIST_W-1:0]  d;
        logic [DECEL_W-1:0] a;
        logic [63:0]        x;
        logic [31:0]        s;
        logic [31:0]        sup;
        v = allowed;
        if (pstop || asp == ASPECT_STOP_BOARD)
            v = '0;
        else if (shunt)
        begin
            if (asp == ASPECT_STOP)
                v = '0;
        end
        else if (asp != ASPECT_PROCEED && asp != ASPECT_PROCEED_LIMITED)
            v = '0;
        if (limit < v)
            v = limit;
        d = (dist_val > DIST_MARGIN) ? dist_val - DIST_MARGIN : '0;
        a = (decel > DECEL_KNEE) ? decel - DECEL_DERATE : decel;
        x = 64'd10000 * 64'(v) * 64'(v);
        // Within the short distance the curve collapses onto the target speed.
        if (d >= MIN_DIST)
            x = x + 64'd2592 * 64'(a) * 64'(d);
        s = exact_root(x);
        sup = (s < 32'd1332) ? 32'd0 : s / 32'd100;
        if (sup > 32'(MAX_SPEED))
            sup = 32'(MAX_SPEED);
        res.supervised = sup[SPEED_W-1:0];
        res.target     = v;
        return res;
    endfunction

    // Receiver: random stalls, or a long hold while hold_left counts down.
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Result checker.
    always @(posedge clk)
    begin
        speed_result_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (expected_speeds.size() == 0)
            begin
                $error("result with no pending expectation: supervised %0d target %0d",
                       supervised_speed, target_speed);
                error_count++;
            end
            else
            begin
                exp_res = expected_speeds.pop_front();
                if (supervised_speed !== exp_res.supervised)
                begin
                    $error("supervised_speed: expected %0d, actual %0d",
                           exp_res.supervised, supervised_speed);
                    error_count++;
                end
                if (target_speed !== exp_res.target)
                begin
                    $error("target_speed: expected %0d, actual %0d",
                           exp_res.target, target_speed);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("[braking_curve_speed_supervisor] ERROR");
            $finish;
        end
    end

    task automatic send_signal(
        input logic [ASPECT_W-1:0] asp,
        input logic [DIST_W-1:0]   dist_val,
        input logic [SPEED_W-1:0]  allowed,
        input logic                pstop,
        input logic                shunt,
        input logic [SPEED_W-1:0]  limit
    );
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        aspect         <= asp;
        distance_m     <= dist_val;
        allowed_speed  <= allowed;
        platform_stop  <= pstop;
        shunting       <= shunt;
        combined_limit <= limit;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_speeds.push_back(
            predict_speeds(asp, dist_val, allowed, pstop, shunt, limit, decel_setting));
        signals_sent++;
    endtask

    task automatic send_random_signal();
        logic [ASPECT_W-1:0] asp;
        logic [DIST_W-1:0]   dist_val;
        logic [SPEED_W-1:0]  allowed;
        logic [SPEED_W-1:0]  limit;
        logic                pstop;
        asp = ASPECT_W'($urandom_range(7));
        case ($urandom_range(3))
            0: dist_val = DIST_W'($urandom_range(40));
            1: dist_val = DIST_W'($urandom_range(2000));
            default: dist_val = DIST_W'($urandom);
        endcase
        allowed = ($urandom_range(3) == 0) ? SPEED_W'($urandom_range(30))
                                           : SPEED_W'($urandom);
        case ($urandom_range(5))
            0, 1: limit = '1;
            2: limit = SPEED_W'($urandom_range(30));
            default: limit = SPEED_W'($urandom);
        endcase
        // Mostly no platform stop, so the curve itself gets exercised.
        pstop = ($urandom_range(7) == 0);
        send_signal(asp, dist_val, allowed, pstop, 1'($urandom), limit);
    endtask

    // Lets the pipeline run dry before a register write or the end of the run.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (expected_speeds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_deceleration(input logic [DECEL_W-1:0] value);
        wait_drain();
        cfg_valid          <= 1'b1;
        deceleration_centi <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid     <= 1'b0;
        decel_setting = value;
        decel_writes++;
    endtask

    // Runs on the reset value of the deceleration register.
    task automatic test_directed_cases();
        int asp;
        int sh;
        send_idle_pct = 28;
        recv_idle_pct = 83;
        for (asp = 0; asp < 8; asp++)
            for (sh = 0; sh < 2; sh++)
                send_signal(ASPECT_W'(asp), 16'd1000, 9'd120, 1'b0, 1'(sh), '1);
        send_signal(ASPECT_PROCEED, 16'd1000, 9'd120, 1'b1, 1'b0, '1);
        send_signal(ASPECT_PROCEED, 16'd0, '1, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED, DIST_MARGIN, '1, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED, 16'd24, 9'd0, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED, 16'd25, 9'd0, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED_LIMITED, '1, '1, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED, '1, 9'd0, 1'b0, 1'b1, 9'd0);
        send_signal(ASPECT_PROCEED, 16'd500, 9'd200, 1'b0, 1'b0, 9'd40);
        // Either side of the lowest speed that is still supervised.
        send_signal(ASPECT_PROCEED, 16'd0, 9'd13, 1'b0, 1'b0, '1);
        send_signal(ASPECT_PROCEED, 16'd0, 9'd14, 1'b0, 1'b0, '1);
    endtask

    // Zero deceleration, just past the knee, the top of the range and beyond it.
    task automatic test_deceleration_extremes();
        logic [DECEL_W-1:0] settings[4];
        int i;
        settings = '{9'd0, 9'd51, 9'd500, 9'd511};
        for (i = 0; i < 4; i++)
        begin
            write_deceleration(settings[i]);
            send_signal(ASPECT_PROCEED, '1, 9'd0, 1'b0, 1'b0, '1);
            send_signal(ASPECT_PROCEED, '1, '1, 1'b0, 1'b1, '1);
            send_signal(ASPECT_PROCEED, 16'd25, 9'd0, 1'b0, 1'b0, '1);
            send_signal(ASPECT_PROCEED_LIMITED, 16'd300, 9'd60, 1'b0, 1'b0, '1);
            send_signal(ASPECT_STOP, 16'd5000, 9'd80, 1'b0, 1'b1, '1);
        end
    endtask

    task automatic test_random_traffic();
        int send_pcts[3];
        int recv_pcts[3];
        logic [DECEL_W-1:0] extremes[4];
        int p;
        int k;
        int n;
        send_pcts = '{28, 83, 0};
        recv_pcts = '{83, 28, 0};
        extremes  = '{9'd0, DECEL_RESET, 9'd500, 9'd511};
        for (p = 0; p < 3; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_idle_pct = recv_pcts[p];
            for (k = 0; k < 4; k++)
            begin
                if ($urandom_range(3) == 0)
                    write_deceleration(extremes[$urandom_range(3)]);
                else
                    write_deceleration(DECEL_W'($urandom));
                for (n = 0; n < 170; n++)
                    send_random_signal();
            end
        end
    endtask

    // The output holds off for a long stretch while the sender keeps offering.
    task automatic test_back_pressure();
        int n;
        write_deceleration(DECEL_W'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = HOLD_CYCLES;
        for (n = 0; n < 120; n++)
            send_random_signal();
        recv_idle_pct = 50;
        for (n = 0; n < 60; n++)
            send_random_signal();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_deceleration_extremes();
        test_random_traffic();
        test_back_pressure();
        wait_drain();
        $display("Checked %0d results from %0d signals across %0d deceleration settings,",
                 results_seen, signals_sent, decel_writes + 1);
        $display("with idling on either side, no idling, and a long output hold.");
        if (error_count == 0)
            $display("[braking_curve_speed_supervisor] OK");
        else
            $display("[braking_curve_speed_supervisor] ERROR");
        $finish;
    end

endmodule
